>>> hw/rtl/hshf_pkg.sv
// Package for the heater state hysteresis filter.
// Holds configuration register indexes, the configuration struct and field widths.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package hshf_pkg;

  localparam int THRESH_BITS   = 16;
  localparam int COUNT_BITS    = 8;
  localparam int SEEN_BITS     = 9;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  localparam logic [SEEN_BITS-1:0] SEEN_MAX = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODE_ADVANCED    = 3'd0,
    REG_THRESHOLD_SINGLE = 3'd1,
    REG_THRESHOLD_ON     = 3'd2,
    REG_THRESHOLD_OFF    = 3'd3,
    REG_DEBOUNCE_ON      = 3'd4,
    REG_DEBOUNCE_OFF     = 3'd5,
    REG_INERTIA_ON       = 3'd6,
    REG_INERTIA_OFF      = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic                          mode_advanced;
    logic signed [THRESH_BITS-1:0] threshold_single;
    logic signed [THRESH_BITS-1:0] threshold_on;
    logic signed [THRESH_BITS-1:0] threshold_off;
    logic [COUNT_BITS-1:0]         debounce_on;
    logic [COUNT_BITS-1:0]         debounce_off;
    logic [COUNT_BITS-1:0]         inertia_on;
    logic [COUNT_BITS-1:0]         inertia_off;
  } cfg_t;

endpackage

>>> hw/rtl/hshf_cfg.sv
// Configuration register file of the heater state hysteresis filter.
// Decodes the plain write port into the cfg_t struct; depends on hshf_pkg.
`timescale 1ns / 1ps

module hshf_cfg
  import hshf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_addr))
        REG_MODE_ADVANCED:    cfg.mode_advanced    <= cfg_wdata[0];
        REG_THRESHOLD_SINGLE: cfg.threshold_single <= cfg_wdata[THRESH_BITS-1:0];
        REG_THRESHOLD_ON:     cfg.threshold_on     <= cfg_wdata[THRESH_BITS-1:0];
        REG_THRESHOLD_OFF:    cfg.threshold_off    <= cfg_wdata[THRESH_BITS-1:0];
        REG_DEBOUNCE_ON:      cfg.debounce_on      <= cfg_wdata[COUNT_BITS-1:0];
        REG_DEBOUNCE_OFF:     cfg.debounce_off     <= cfg_wdata[COUNT_BITS-1:0];
        REG_INERTIA_ON:       cfg.inertia_on       <= cfg_wdata[COUNT_BITS-1:0];
        REG_INERTIA_OFF:      cfg.inertia_off      <= cfg_wdata[COUNT_BITS-1:0];
        default:              cfg.mode_advanced    <= cfg.mode_advanced;
      endcase
    end
  end

endmodule

>>> hw/rtl/hshf_state.sv
// Heater state, qualification counter and series item count, plus the
// compare/debounce logic that advances them for one item. Depends on hshf_pkg.
`timescale 1ns / 1ps

module hshf_state
  import hshf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          step,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          series_start,
  output logic                          label_next,
  output logic [SEEN_BITS-1:0]          relabel_count_next
);

  localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

  logic                  heater_on;
  logic [COUNT_BITS-1:0] qualify_count;
  logic [SEEN_BITS-1:0]  items_seen;

  logic                  heater_on_next;
  logic [COUNT_BITS-1:0] qualify_count_next;
  logic [SEEN_BITS-1:0]  items_seen_next;

  logic                  heat_cur;
  logic [COUNT_BITS-1:0] qual_cur;
  logic [SEEN_BITS-1:0]  seen_cur;
  logic                  first;
  logic signed [CMP_BITS-1:0] s_ext, th_single, th_on, th_off;
  logic                  hot, warm, cold;
  logic [SEEN_BITS-1:0]  relabel;

  always_comb begin
    // series start clears the state before this sample is handled
    heat_cur = series_start ? 1'b0 : heater_on;
    qual_cur = series_start ? '0 : qualify_count;
    seen_cur = series_start ? '0 : items_seen;
    first    = (seen_cur == '0);
    items_seen_next = (seen_cur == SEEN_MAX) ? SEEN_MAX : seen_cur + 1'b1;

    s_ext     = CMP_BITS'(sample);
    th_single = CMP_BITS'(cfg.threshold_single);
    th_on     = CMP_BITS'(cfg.threshold_on);
    th_off    = CMP_BITS'(cfg.threshold_off);
    hot  = (s_ext >= th_single);
    warm = (s_ext >= th_on);
    cold = (s_ext < th_off);

    heater_on_next     = heat_cur;
    qualify_count_next = qual_cur;
    relabel            = '0;

    if (!cfg.mode_advanced) begin
      if (first) begin
        heater_on_next = hot;
      end else if (hot && !heat_cur) begin
        heater_on_next = 1'b1;
        relabel        = SEEN_BITS'(cfg.inertia_on) + 1'b1;
      end else if (!hot && heat_cur) begin
        heater_on_next = 1'b0;
        relabel        = SEEN_BITS'(cfg.inertia_off) + 1'b1;
      end
    end else if (heat_cur) begin
      if (cold) begin
        if (qual_cur >= cfg.debounce_off) begin
          qualify_count_next = '0;
          heater_on_next     = 1'b0;
          relabel = SEEN_BITS'(cfg.debounce_off) + SEEN_BITS'(cfg.inertia_off) + 1'b1;
        end else begin
          qualify_count_next = qual_cur + 1'b1;
        end
      end else begin
        qualify_count_next = '0;
      end
    end else begin
      if (warm) begin
        if (qual_cur >= cfg.debounce_on) begin
          qualify_count_next = '0;
          heater_on_next     = 1'b1;
          relabel = SEEN_BITS'(cfg.debounce_on) + SEEN_BITS'(cfg.inertia_on) + 1'b1;
        end else begin
          qualify_count_next = qual_cur + 1'b1;
        end
      end else begin
        qualify_count_next = '0;
      end
    end

    // limit to the items seen in this series
    label_next         = heater_on_next;
    relabel_count_next = (relabel > items_seen_next) ? items_seen_next : relabel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heater_on     <= 1'b0;
      qualify_count <= '0;
      items_seen    <= '0;
    end else if (step) begin
      heater_on     <= heater_on_next;
      qualify_count <= qualify_count_next;
      items_seen    <= items_seen_next;
    end
  end

endmodule

>>> hw/rtl/heat_state_hysteresis_filter_core.sv
// Top level of the heater state hysteresis filter: input register, result register
// and handshakes. Depends on hshf_pkg, hshf_cfg and hshf_state.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one temperature sample per transfer
//   with series_start marking the first sample of a new series.
//   Output channel (out_valid/out_ready) returns one result per input: the heater
//   label and the relabel count (number of most recent items, this one included,
//   that take the label; 0 when no switch happened).
//   Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata, one register per
//   cycle, while the block is idle.
//   A transferred sample is held in the input register, evaluated against the state
//   and moved into the result register once that register is free to take it.
//   Throughput: one item per cycle while out_ready is high; the state update is one
//   compare, one counter step and one add/min between input and result registers.
//   When the receiver stalls, the result register holds and the input register
//   keeps one more item; in_ready drops only when both are full and out_ready is low.
//   Reset clears all configuration registers, the heater state, the qualification
//   counter, the item count and both valid flags.

module heat_state_hysteresis_filter_core
  import hshf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]       cfg_addr,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          series_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          label,
  output logic [SEEN_BITS-1:0]          relabel_count
);

  cfg_t cfg;

  logic                          in_full;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          series_start_q;
  logic                          advance;
  logic                          label_next;
  logic [SEEN_BITS-1:0]          relabel_count_next;

  hshf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hshf_state #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_state (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .step               (advance),
    .sample             (sample_q),
    .series_start       (series_start_q),
    .label_next         (label_next),
    .relabel_count_next (relabel_count_next)
  );

  // move the held item into the result register when that slot frees up
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_q       <= sample;
      series_start_q <= series_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      label         <= label_next;
      relabel_count <= relabel_count_next;
    end
  end

endmodule

>>> dv/heat_state_hysteresis_filter_core_tb.sv
// Testbench for heat_state_hysteresis_filter_core: a queue-fed driver, a checking monitor
// and a behavioral predictor of the heater state, debounce counter and relabel count.
// Depends on hshf_pkg and the core RTL only.
`timescale 1ns / 1ps

module heat_state_hysteresis_filter_core_tb;
  import hshf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 26;
  localparam int LONG_HOLD   = 300;
  localparam int NUM_PHASES  = 12;

  typedef struct {
    logic signed [15:0] value;
    logic               new_series;
  } sample_item_t;

  typedef struct {
    logic                 heat;
    logic [SEEN_BITS-1:0] count;
  } heat_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] sample = '0;
  logic series_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic label;
  logic [SEEN_BITS-1:0] relabel_count;

  // predictor copy of the registers and the filter state
  logic               mode_adv_q;
  logic signed [15:0] thr_single_q, thr_on_q, thr_off_q;
  logic [7:0]         deb_on_q, deb_off_q, inr_on_q, inr_off_q;
  logic               heat_on_q;
  logic [7:0]         qual_cnt_q;
  logic [SEEN_BITS-1:0] seen_cnt_q;

  sample_item_t samples_pending[$];
  heat_result_t heat_results_due[$];

  int  mismatches = 0;
  int  samples_sent = 0;
  int  results_checked = 0;
  int  switches_seen = 0;
  int  cycles = 0;
  int  hold_request = 0;
  int  hold_served = 0;
  int  stall_left = 0;
  bit  steady = 1'b0;

  heat_state_hysteresis_filter_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .series_start (series_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .label        (label),
    .relabel_count(relabel_count)
  );

  always #5 clk = ~clk;

  function automatic heat_result_t predict_heat_result(logic signed [15:0] s, logic restart);
    logic         first;
    logic         hot;
    logic [9:0]   relabel;
    heat_result_t r;
    relabel = '0;
    if (restart) begin
      heat_on_q  = 1'b0;
      qual_cnt_q = '0;
      seen_cnt_q = '0;
    end
    first = (seen_cnt_q == '0);
    if (seen_cnt_q != SEEN_MAX) seen_cnt_q = seen_cnt_q + 1'b1;
    if (!mode_adv_q) begin
      hot = (s >= thr_single_q);
      if (first) begin
        heat_on_q = hot;
      end else if (hot && !heat_on_q) begin
        heat_on_q = 1'b1;
        relabel = {2'b0, inr_on_q} + 10'd1;
      end else if (!hot && heat_on_q) begin
        heat_on_q = 1'b0;
        relabel = {2'b0, inr_off_q} + 10'd1;
      end
    end else if (heat_on_q) begin
      if (s < thr_off_q) begin
        if (qual_cnt_q >= deb_off_q) begin
          qual_cnt_q = '0;
          heat_on_q = 1'b0;
          relabel = {2'b0, deb_off_q} + {2'b0, inr_off_q} + 10'd1;
        end else begin
          qual_cnt_q = qual_cnt_q + 1'b1;
        end
      end else begin
        qual_cnt_q = '0;
      end
    end else begin
      if (s >= thr_on_q) begin
        if (qual_cnt_q >= deb_on_q) begin
          qual_cnt_q = '0;
          heat_on_q = 1'b1;
          relabel = {2'b0, deb_on_q} + {2'b0, inr_on_q} + 10'd1;
        end else begin
          qual_cnt_q = qual_cnt_q + 1'b1;
        end
      end else begin
        qual_cnt_q = '0;
      end
    end
    // limit to the items of the current series
    if (relabel > {1'b0, seen_cnt_q}) relabel = {1'b0, seen_cnt_q};
    r.heat  = heat_on_q;
    r.count = relabel[SEEN_BITS-1:0];
    return r;
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %0s at result %0d: expected %0d, got %0d",
               what, results_checked, want, got);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MODE_ADVANCED:    mode_adv_q   = val[0];
      REG_THRESHOLD_SINGLE: thr_single_q = val;
      REG_THRESHOLD_ON:     thr_on_q     = val;
      REG_THRESHOLD_OFF:    thr_off_q    = val;
      REG_DEBOUNCE_ON:      deb_on_q     = val[7:0];
      REG_DEBOUNCE_OFF:     deb_off_q    = val[7:0];
      REG_INERTIA_ON:       inr_on_q     = val[7:0];
      REG_INERTIA_OFF:      inr_off_q    = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_regs(logic mode, logic signed [15:0] ts, logic signed [15:0] ton,
                          logic signed [15:0] toff, logic [7:0] don, logic [7:0] doff,
                          logic [7:0] ion, logic [7:0] ioff);
    write_reg(REG_MODE_ADVANCED, {15'b0, mode});
    write_reg(REG_THRESHOLD_SINGLE, ts);
    write_reg(REG_THRESHOLD_ON, ton);
    write_reg(REG_THRESHOLD_OFF, toff);
    write_reg(REG_DEBOUNCE_ON, {8'b0, don});
    write_reg(REG_DEBOUNCE_OFF, {8'b0, doff});
    write_reg(REG_INERTIA_ON, {8'b0, ion});
    write_reg(REG_INERTIA_OFF, {8'b0, ioff});
  endtask

  task automatic push_sample(logic signed [15:0] v, logic restart);
    sample_item_t it;
    it.value = v;
    it.new_series = restart;
    samples_pending.push_back(it);
  endtask

  // Hot and cold runs of random length around the thresholds, with some noise.
  task automatic push_runs(int count, logic signed [15:0] hi, logic signed [15:0] lo,
                           int min_run, int max_run, int noise_pct, int start_pct);
    int n, len, j, offs;
    bit hot;
    logic signed [15:0] v;
    n = 0;
    while (n < count) begin
      hot = 1'($urandom_range(0, 1));
      len = $urandom_range(min_run, max_run);
      for (j = 0; j < len && n < count; j++) begin
        offs = $urandom_range(0, 300);
        if ($urandom_range(0, 99) < noise_pct) v = 16'($urandom);
        else if (hot) v = clamp16(int'(hi) + offs);
        else v = clamp16(int'(lo) - 1 - offs);
        push_sample(v, (j == 0) && ($urandom_range(0, 99) < start_pct));
        n++;
      end
    end
  endtask

  // Hold the sender until every expected result is back.
  task automatic drain();
    while (samples_pending.size() != 0 || in_valid || heat_results_due.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin : drive_inputs
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        heat_results_due.push_back(
          predict_heat_result(samples_pending[0].value, samples_pending[0].new_series));
        void'(samples_pending.pop_front());
        samples_sent++;
        offer = 1'b0;
      end
      if (!offer && samples_pending.size() != 0 &&
          (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        offer = 1'b1;
        sample <= samples_pending[0].value;
        series_start <= samples_pending[0].new_series;
      end
      in_valid <= offer;
    end
  end

  always @(posedge clk) begin : check_outputs
    heat_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (heat_results_due.size() == 0) begin
          note_mismatch("unexpected result, relabel_count", 0, int'(relabel_count));
        end else begin
          want = heat_results_due.pop_front();
          if (label !== want.heat) note_mismatch("label", int'(want.heat), int'(label));
          if (relabel_count !== want.count)
            note_mismatch("relabel_count", int'(want.count), int'(relabel_count));
          if (want.count != 0) switches_seen++;
        end
        results_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_request != hold_served) begin
        hold_served++;
        stall_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int p, base, len, min_run, max_run, noise, starts;
    logic signed [15:0] hi, lo, t_on, t_off;
    mode_adv_q = 1'b0;
    thr_single_q = '0;
    thr_on_q = '0;
    thr_off_q = '0;
    deb_on_q = '0;
    deb_off_q = '0;
    inr_on_q = '0;
    inr_off_q = '0;
    heat_on_q = 1'b0;
    qual_cnt_q = '0;
    seen_cnt_q = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // simple mode: first item sets the state, crossings switch at once, limit by series
    set_regs(1'b0, 16'sd0, 16'sd100, -16'sd100, 8'd2, 8'd1, 8'd3, 8'd255);
    push_sample(-16'sd32768, 1'b1);
    push_sample(16'sd32767, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd0, 1'b1);
    push_sample(-16'sd1, 1'b0);
    drain();

    // advanced mode: debounce runs, broken runs, switch both ways
    set_regs(1'b1, 16'sd0, 16'sd100, -16'sd100, 8'd2, 8'd1, 8'd0, 8'd5);
    push_sample(16'sd100, 1'b1);
    push_sample(16'sd100, 1'b0);
    push_sample(16'sd32767, 1'b0);
    push_sample(-16'sd101, 1'b0);
    push_sample(-16'sd100, 1'b0);
    push_sample(-16'sd101, 1'b0);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sd99, 1'b0);
    drain();

    // change mode in the middle of a series, both directions
    set_regs(1'b0, 16'sd50, 16'sd100, -16'sd100, 8'd2, 8'd1, 8'd0, 8'd5);
    push_sample(16'sd50, 1'b0);
    push_sample(16'sd49, 1'b0);
    drain();
    set_regs(1'b1, 16'sd50, 16'sd100, -16'sd100, 8'd2, 8'd1, 8'd0, 8'd5);
    push_sample(16'sd200, 1'b0);
    push_sample(16'sd300, 1'b0);
    push_sample(16'sd101, 1'b0);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      base = int'($urandom_range(0, 65535)) - 32768;
      t_on = clamp16(base + int'($urandom_range(0, 2000)));
      t_off = clamp16(base - int'($urandom_range(0, 2000)));
      len = 85;
      min_run = 1;
      max_run = 12;
      noise = 12;
      starts = 8;
      steady = (p == 4);
      hi = t_on;
      lo = t_off;
      case (p % 6)
        0: begin
          hi = clamp16(base);
          lo = hi;
          set_regs(1'b0, hi, t_on, t_off,
                   8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        1: set_regs(1'b1, clamp16(base), t_on, t_off,
                    8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        2: begin
          // overlapping thresholds: on level below off level
          hi = t_off;
          lo = t_on;
          set_regs(1'b1, clamp16(base), t_off, t_on,
                   8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                   8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)));
        end
        3: begin
          set_regs(1'b1, clamp16(base), t_on, t_off, 8'd255, 8'd255, 8'd255, 8'd255);
          min_run = 250;
          max_run = 300;
          noise = 0;
          starts = 0;
          len = (p == 9) ? 600 : 320;
        end
        4: set_regs(1'b1, clamp16(base), t_on, t_off, 8'd0, 8'd0, 8'd0, 8'd0);
        default: begin
          hi = (p == 5) ? -16'sd32768 : 16'sd32767;
          lo = hi;
          set_regs(1'b0, hi, t_on, t_off, 8'd255, 8'd255, 8'd255, 8'd255);
          noise = 40;
        end
      endcase
      push_runs(len, hi, lo, min_run, max_run, noise, starts);
      // long receiver stall with the input queue full
      if (p == 1 || p == 7) hold_request++;
      drain();
    end
    steady = 1'b0;

    $display("run covered %0d samples, %0d results checked, %0d with a relabel count",
             samples_sent, results_checked, switches_seen);
    $display("modes: simple and advanced, debounce/inertia 0..255, thresholds at both ends");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
